FILE: rtl/core/slab_object_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// Slab allocator assertion macros
// Clocked assertion helpers used by the port checker file.
// ----------------------------------------------------------------------------
`ifndef SLAB_OBJECT_ALLOCATOR_CORE_ASSERT_SVH
`define SLAB_OBJECT_ALLOCATOR_CORE_ASSERT_SVH

// checked only while out of reset
`define SOA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
  else $error(msg);

// checked at every edge, reset included
`define SOA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/core/soa_pkg.sv
// ----------------------------------------------------------------------------
// Slab allocator package
// Sizes, page record layout, status codes and controller command types.
// ----------------------------------------------------------------------------
package soa_pkg;

  localparam int NUM_PAGES    = 256;
  localparam int PAGE_BYTES   = 4096;
  localparam int HEADER_BYTES = 40;
  localparam int MIN_SHIFT    = 4;
  localparam int MAX_SHIFT    = 11;
  localparam int MAX_OBJS     = 253;

  localparam int NUM_CLASSES = MAX_SHIFT - MIN_SHIFT + 1;
  localparam int ADDR_W      = 20;
  localparam int SIZE_W      = 20;
  localparam int OFF_W       = $clog2(PAGE_BYTES);
  localparam int PAGE_W      = $clog2(NUM_PAGES);
  localparam int PTR_W       = PAGE_W + 1;
  localparam int IDX_W       = $clog2(MAX_OBJS + 1);
  localparam int CLS_W       = $clog2(NUM_CLASSES);
  localparam int LINK_DEPTH  = NUM_PAGES * MAX_OBJS;
  localparam int LINK_AW     = $clog2(LINK_DEPTH);

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_LARGE     = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_NOT_SLAB  = 3'd4,
    ST_NULL      = 3'd5
  } status_e;

  // per-page slab record; untouched = objects below it still hold their
  // initial chain and have no link entry written yet
  typedef struct packed {
    logic [CLS_W-1:0] cls;
    logic [IDX_W-1:0] head;
    logic [IDX_W-1:0] count;
    logic [PTR_W-1:0] next;
    logic [IDX_W-1:0] untouched;
  } rec_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_DEC,
    OP_NEWSLAB,
    OP_RECRD,
    OP_RECCAP,
    OP_POP,
    OP_POPRD,
    OP_FCHK,
    OP_MAT,
    OP_PUSH,
    OP_REPORT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic dec_err;
    logic need_new;
    logic pop_fast;
    logic free_done;
    logic free_mat;
    logic mat_more;
  } sts_t;

  function automatic logic [IDX_W-1:0] cap_of(input logic [CLS_W-1:0] cls);
    int c;
    c = (PAGE_BYTES - HEADER_BYTES) >> (MIN_SHIFT + int'(cls));
    if (c > MAX_OBJS) c = MAX_OBJS;
    return IDX_W'(c);
  endfunction

  function automatic logic [CLS_W-1:0] cls_of(input logic [SIZE_W-1:0] size);
    logic [CLS_W-1:0] c;
    c = CLS_W'(NUM_CLASSES - 1);
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if (32'(size) <= (32'd1 << (MIN_SHIFT + k))) c = CLS_W'(k);
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/soa_if.sv
// ----------------------------------------------------------------------------
// Slab allocator channels
// Request and response valid/ready interfaces.
// ----------------------------------------------------------------------------
interface soa_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [19:0] req_size;
  logic [19:0] free_address;
  modport source (output valid, func, req_size, free_address, input ready);
  modport sink   (input valid, func, req_size, free_address, output ready);
endinterface

interface soa_rsp_if;
  logic        valid;
  logic        ready;
  logic [19:0] obj_address;
  logic [2:0]  status;
  modport source (output valid, obj_address, status, input ready);
  modport sink   (input valid, obj_address, status, output ready);
endinterface

FILE: rtl/core/soa_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module soa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

FILE: rtl/core/soa_ctrl.sv
// ----------------------------------------------------------------------------
// Slab allocator controller
// Sequences decode, record access, link access and result hand-off.
// ----------------------------------------------------------------------------
module soa_ctrl import soa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_NEW, S_RECRD, S_RECCAP, S_POP, S_POPRD,
    S_FCHK, S_FMAT, S_FPUSH, S_REPORT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.op = OP_NONE;
    unique case (state_q)
      S_IDLE:   cmd_o.op = in_valid_i ? OP_LATCH : OP_NONE;
      S_DEC:    cmd_o.op = OP_DEC;
      S_NEW:    cmd_o.op = OP_NEWSLAB;
      S_RECRD:  cmd_o.op = OP_RECRD;
      S_RECCAP: cmd_o.op = OP_RECCAP;
      S_POP:    cmd_o.op = OP_POP;
      S_POPRD:  cmd_o.op = OP_POPRD;
      S_FCHK:   cmd_o.op = OP_FCHK;
      S_FMAT:   cmd_o.op = OP_MAT;
      S_FPUSH:  cmd_o.op = OP_PUSH;
      S_REPORT: cmd_o.op = slot_free ? OP_REPORT : OP_NONE;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_DEC;
        end
        S_DEC: begin
          priority if (sts_i.dec_err) state_q <= S_REPORT;
          else if (sts_i.is_free)     state_q <= S_RECRD;
          else if (sts_i.need_new)    state_q <= S_NEW;
          else                        state_q <= S_RECRD;
        end
        S_NEW:    state_q <= S_POP;
        S_RECRD:  state_q <= S_RECCAP;
        S_RECCAP: state_q <= sts_i.is_free ? S_FCHK : S_POP;
        S_POP:    state_q <= sts_i.pop_fast ? S_REPORT : S_POPRD;
        S_POPRD:  state_q <= S_REPORT;
        S_FCHK: begin
          priority if (sts_i.free_done) state_q <= S_REPORT;
          else if (sts_i.free_mat)      state_q <= S_FMAT;
          else                          state_q <= S_FPUSH;
        end
        S_FMAT: begin
          if (!sts_i.mat_more) state_q <= S_FPUSH;
        end
        S_FPUSH:  state_q <= S_REPORT;
        S_REPORT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/soa_datapath.sv
// ----------------------------------------------------------------------------
// Slab allocator datapath
// Class heads, slab flags, page record RAM, object link RAM and result regs.
// ----------------------------------------------------------------------------
module soa_datapath import soa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic              in_func_i,
  input  logic [SIZE_W-1:0] in_req_size_i,
  input  logic [ADDR_W-1:0] in_free_address_i,
  output logic [ADDR_W-1:0] out_obj_address_o,
  output logic [2:0]        out_status_o
);

  logic                func_q;
  logic [SIZE_W-1:0]   size_q;
  logic [ADDR_W-1:0]   faddr_q;
  logic [CLS_W-1:0]    cls_q;
  logic [PAGE_W-1:0]   page_q;
  rec_t                rec_q;
  logic [LINK_AW-1:0]  base_q;
  logic [IDX_W-1:0]    idx_q;
  logic [IDX_W-1:0]    j_q;
  logic [ADDR_W-1:0]   res_addr_q;
  status_e             res_status_q;
  logic [ADDR_W-1:0]   out_addr_q;
  status_e             out_status_q;

  logic [PTR_W-1:0]     next_unused_q;
  logic [NUM_PAGES-1:0] is_slab_q;
  logic [PTR_W-1:0]     class_head_q [NUM_CLASSES];

  // decode
  logic [CLS_W-1:0]  cls_a;
  logic [PTR_W-1:0]  head_a;
  logic [IDX_W-1:0]  cap_n;
  logic              need_new;
  logic              exhausted;
  logic [PAGE_W-1:0] page_f;
  logic [OFF_W-1:0]  off_f;
  status_e           dec_code;

  // pop
  logic [IDX_W-1:0]  idx_p;
  logic              fast;
  logic [IDX_W-1:0]  nxt_def;
  logic [IDX_W-1:0]  nxt_sel;
  rec_t              pop_rec;
  logic [ADDR_W-1:0] addr_p;

  // free
  logic [IDX_W-1:0]  cap_f;
  logic [OFF_W-1:0]  off_rel;
  logic [OFF_W-1:0]  idx_full;
  logic [IDX_W-1:0]  idx_f;
  logic              bad_f;
  logic              full_f;
  rec_t              push_rec;
  rec_t              new_rec;

  // memories
  logic               rec_we;
  logic [PAGE_W-1:0]  rec_addr;
  rec_t               rec_wdata;
  rec_t               rec_rdata;
  logic               link_we;
  logic [LINK_AW-1:0] link_addr;
  logic [IDX_W-1:0]   link_wdata;
  logic [IDX_W-1:0]   link_rdata;

  assign cls_a     = cls_of(size_q);
  assign head_a    = class_head_q[cls_a];
  assign cap_n     = cap_of(cls_a);
  assign need_new  = head_a >= PTR_W'(NUM_PAGES);
  assign exhausted = (next_unused_q >= PTR_W'(NUM_PAGES)) || (cap_n == '0);
  assign page_f    = faddr_q[ADDR_W-1:OFF_W];
  assign off_f     = faddr_q[OFF_W-1:0];

  always_comb begin
    dec_code = ST_OK;
    if (!func_q) begin
      priority if (size_q == '0)                        dec_code = ST_ZERO;
      else if (32'(size_q) > (32'd1 << MAX_SHIFT))      dec_code = ST_LARGE;
      else if (need_new && exhausted)                   dec_code = ST_EXHAUSTED;
      else                                              dec_code = ST_OK;
    end else begin
      priority if (faddr_q == '0)                       dec_code = ST_NULL;
      else if (!is_slab_q[page_f] ||
               32'(off_f) < HEADER_BYTES)               dec_code = ST_NOT_SLAB;
      else                                              dec_code = ST_OK;
    end
  end

  assign new_rec = '{cls: cls_a, head: cap_n - IDX_W'(1), count: cap_n,
                     next: head_a, untouched: cap_n};

  // objects below the untouched mark still follow the initial chain
  assign idx_p   = rec_q.head;
  assign fast    = idx_p < rec_q.untouched;
  assign nxt_def = (idx_p == '0) ? '0 : idx_p - IDX_W'(1);
  assign nxt_sel = (cmd_i.op == OP_POPRD) ? link_rdata : nxt_def;

  always_comb begin
    pop_rec       = rec_q;
    pop_rec.head  = nxt_sel;
    pop_rec.count = (rec_q.count != '0) ? rec_q.count - IDX_W'(1) : '0;
    if (cmd_i.op == OP_POP) pop_rec.untouched = idx_p;
  end

  assign addr_p = ADDR_W'({page_q, {OFF_W{1'b0}}}) + ADDR_W'(HEADER_BYTES)
                + (ADDR_W'(idx_p) << (MIN_SHIFT + int'(cls_q)));

  assign cap_f    = cap_of(rec_q.cls);
  assign off_rel  = off_f - OFF_W'(HEADER_BYTES);
  assign idx_full = off_rel >> (MIN_SHIFT + int'(rec_q.cls));
  assign idx_f    = IDX_W'(idx_full);
  assign bad_f    = 32'(idx_full) >= 32'(cap_f);
  assign full_f   = rec_q.count >= cap_f;

  always_comb begin
    push_rec       = rec_q;
    push_rec.head  = idx_q;
    push_rec.count = rec_q.count + IDX_W'(1);
    if (idx_q < rec_q.untouched) push_rec.untouched = idx_q;
    if (rec_q.count == '0) push_rec.next = class_head_q[rec_q.cls];
  end

  always_comb begin
    sts_o.is_free   = func_q;
    sts_o.dec_err   = (dec_code != ST_OK);
    sts_o.need_new  = need_new;
    sts_o.pop_fast  = fast;
    sts_o.free_done = bad_f || full_f;
    sts_o.free_mat  = idx_f < rec_q.untouched;
    sts_o.mat_more  = j_q > idx_q;
  end

  always_comb begin
    rec_we    = 1'b0;
    rec_addr  = page_q;
    rec_wdata = pop_rec;
    unique case (cmd_i.op)
      OP_NEWSLAB: begin
        rec_we    = 1'b1;
        rec_addr  = next_unused_q[PAGE_W-1:0];
        rec_wdata = new_rec;
      end
      OP_POP:   rec_we = fast;
      OP_POPRD: rec_we = 1'b1;
      OP_PUSH: begin
        rec_we    = 1'b1;
        rec_wdata = push_rec;
      end
      default:  rec_we = 1'b0;
    endcase
  end

  always_comb begin
    link_we    = 1'b0;
    link_addr  = base_q + LINK_AW'(idx_p);
    link_wdata = nxt_def;
    unique case (cmd_i.op)
      OP_POP:  link_we = fast;
      OP_MAT: begin
        link_we    = j_q > idx_q;
        link_addr  = base_q + LINK_AW'(j_q);
        link_wdata = j_q - IDX_W'(1);
      end
      OP_PUSH: begin
        link_we    = 1'b1;
        link_addr  = base_q + LINK_AW'(idx_q);
        link_wdata = rec_q.head;
      end
      default: link_we = 1'b0;
    endcase
  end

  soa_ram #(.WIDTH($bits(rec_t)), .DEPTH(NUM_PAGES)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .addr_i  (rec_addr),
    .wdata_i (rec_wdata),
    .rdata_o (rec_rdata)
  );

  soa_ram #(.WIDTH(IDX_W), .DEPTH(LINK_DEPTH)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .addr_i  (link_addr),
    .wdata_i (link_wdata),
    .rdata_o (link_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_unused_q <= '0;
      is_slab_q     <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) class_head_q[c] <= PTR_W'(NUM_PAGES);
    end else begin
      unique case (cmd_i.op)
        OP_NEWSLAB: begin
          next_unused_q                        <= next_unused_q + PTR_W'(1);
          is_slab_q[next_unused_q[PAGE_W-1:0]] <= 1'b1;
          class_head_q[cls_q]                  <= PTR_W'(next_unused_q);
        end
        OP_POP, OP_POPRD: begin
          if ((cmd_i.op == OP_POPRD || fast) && pop_rec.count == '0)
            class_head_q[cls_q] <= rec_q.next;
        end
        OP_PUSH: begin
          if (rec_q.count == '0) class_head_q[rec_q.cls] <= PTR_W'(page_q);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LATCH: begin
        func_q  <= in_func_i;
        size_q  <= in_req_size_i;
        faddr_q <= in_free_address_i;
      end
      OP_DEC: begin
        res_status_q <= dec_code;
        res_addr_q   <= '0;
        cls_q        <= cls_a;
        page_q       <= func_q ? page_f : head_a[PAGE_W-1:0];
      end
      OP_NEWSLAB: begin
        page_q <= next_unused_q[PAGE_W-1:0];
        rec_q  <= new_rec;
        base_q <= LINK_AW'(32'(next_unused_q) * MAX_OBJS);
      end
      OP_RECRD:  base_q <= LINK_AW'(32'(page_q) * MAX_OBJS);
      OP_RECCAP: rec_q  <= rec_rdata;
      OP_POP: begin
        if (fast) res_addr_q <= addr_p;
      end
      OP_POPRD:  res_addr_q <= addr_p;
      OP_FCHK: begin
        res_status_q <= bad_f ? ST_NOT_SLAB : ST_OK;
        idx_q        <= idx_f;
        j_q          <= rec_q.untouched - IDX_W'(1);
      end
      OP_MAT: begin
        if (j_q > idx_q) j_q <= j_q - IDX_W'(1);
      end
      OP_REPORT: begin
        out_addr_q   <= res_addr_q;
        out_status_q <= res_status_q;
      end
      default: ;
    endcase
  end

  assign out_obj_address_o = out_addr_q;
  assign out_status_o      = out_status_q;

endmodule

FILE: rtl/core/slab_object_allocator_core.sv
// ----------------------------------------------------------------------------
// Slab object allocator core
// Power-of-two size class slab allocator over a pool of pages.
// ----------------------------------------------------------------------------
// One request is worked at a time. An allocate from an existing partial slab
// reads its page record before the pop, and one that opens a new slab writes
// a fresh record and pops from it without a record read. A free reads the page
// record before its check, and a request rejected at decode goes straight to
// its result. The sequence is set by the single-port page record RAM and object
// link RAM, each read with a registered port. Objects of a fresh slab are
// chained lazily: no link is written at slab creation, and a free of an object
// that was never handed out first writes the initial links above it, one per
// cycle. No clearing pass runs after reset. A finished result waits in an
// output register while the next request is accepted.
module slab_object_allocator_core import soa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  soa_req_if.sink   req_i,
  soa_rsp_if.source rsp_o
);

  cmd_t cmd;
  sts_t sts;

  soa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  soa_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_func_i         (req_i.func),
    .in_req_size_i     (req_i.req_size),
    .in_free_address_i (req_i.free_address),
    .out_obj_address_o (rsp_o.obj_address),
    .out_status_o      (rsp_o.status)
  );

endmodule

FILE: rtl/core/soa_checker.sv
// ----------------------------------------------------------------------------
// Slab allocator port checker
// Handshake and result checks on the top level ports.
// ----------------------------------------------------------------------------
`include "slab_object_allocator_core_assert.svh"

module soa_checker import soa_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [19:0] rsp_obj_address_i,
  input logic [2:0]  rsp_status_i
);

  `SOA_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i, "response beat dropped")
  `SOA_ASSERT(a_rsp_stable, rsp_valid_i && !rsp_ready_i |=> $stable(rsp_obj_address_i) && $stable(rsp_status_i), "stalled response changed")
  `SOA_ASSERT(a_one_at_a_time, req_valid_i && req_ready_i |=> !req_ready_i, "request accepted while busy")
  `SOA_ASSERT(a_fail_zero_addr, rsp_valid_i && rsp_status_i != ST_OK |-> rsp_obj_address_i == '0, "failed request gave an address")
  `SOA_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !rsp_valid_i, "response valid in reset")

endmodule

bind slab_object_allocator_core soa_checker u_soa_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_obj_address_i (rsp_o.obj_address),
  .rsp_status_i      (rsp_o.status)
);
